>>> sv/kml_pkg.sv
// Shared constants, codes and types of the k-means clustering engine.
package kml_pkg;

    // Default sizes of the stores
    localparam int KML_MAX_POINTS   = 1024;
    localparam int KML_MAX_FEATURES = 8;
    localparam int KML_MAX_CLUSTERS = 16;

    // Fixed widths of the data path
    localparam int VAL_W = 16;
    localparam int SUM_W = 32;
    localparam int CFG_W = 16;

    // Item kinds
    localparam logic [2:0] KIND_LOAD_CTR = 3'd0;
    localparam logic [2:0] KIND_LOAD_PT  = 3'd1;
    localparam logic [2:0] KIND_RUN      = 3'd2;
    localparam logic [2:0] KIND_READ_MEM = 3'd3;
    localparam logic [2:0] KIND_READ_CTR = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_NUM_FEATURES   = 3'd0;
    localparam logic [2:0] REG_NUM_CLUSTERS   = 3'd1;
    localparam logic [2:0] REG_NUM_POINTS     = 3'd2;
    localparam logic [2:0] REG_LOOP_LIMIT     = 3'd3;
    localparam logic [2:0] REG_THRESHOLD_Q16  = 3'd4;
    localparam logic [2:0] REG_THRESHOLD_MODE = 3'd5;

    // Strobes broadcast from the sequencer to every cluster cell
    typedef struct packed {
        logic acc_clr;   // start a new distance sum
        logic feat_vld;  // a point feature is on the broadcast bus
        logic pass_clr;  // clear sums and counts for a new pass
        logic upd;       // add the buffered point to the picked cluster
        logic div_load;  // load the divider with one feature sum
        logic div_step;  // one restoring division step
        logic div_wr;    // write the quotient back as the new center
        logic ld_ctr;    // load one center feature
    } t_cell_op;

endpackage

>>> sv/kml_cell.sv
// One cluster cell: center, distance, sums, count, divider and a stage of the min chain.
module kml_cell #(
    parameter int IDX          = 0,
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_FEATURES = 8,
    parameter int MAX_CLUSTERS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kml_pkg::t_cell_op    i_op,
    input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] i_feat_sel,
    input  logic signed [kml_pkg::VAL_W-1:0] i_value,
    input  logic [$clog2(MAX_CLUSTERS+1)-1:0] i_idx,
    input  logic signed [kml_pkg::VAL_W-1:0] i_pt_buf [MAX_FEATURES],
    input  logic [$clog2(MAX_FEATURES+1)-1:0] i_nf,
    input  logic [$clog2(MAX_CLUSTERS+1)-1:0] i_nc,
    input  logic                 i_tok_vld,
    input  logic                 i_tok_have,
    input  logic [32+$clog2(MAX_FEATURES)-1:0] i_tok_dist,
    input  logic [$clog2(MAX_CLUSTERS+1)-1:0] i_tok_idx,
    output logic                 o_tok_vld,
    output logic                 o_tok_have,
    output logic [32+$clog2(MAX_FEATURES)-1:0] o_tok_dist,
    output logic [$clog2(MAX_CLUSTERS+1)-1:0] o_tok_idx,
    output logic signed [kml_pkg::VAL_W-1:0] o_rd_val
);
    import kml_pkg::*;

    localparam int CW = $clog2(MAX_CLUSTERS+1);
    localparam int NW = $clog2(MAX_POINTS+1);
    localparam int DW = 32 + $clog2(MAX_FEATURES);

    logic signed [VAL_W-1:0] r_ctr [MAX_FEATURES];
    logic signed [SUM_W-1:0] r_sum [MAX_FEATURES];
    logic [NW-1:0]           r_cnt;
    logic [31:0]             r_prod;
    logic                    r_pv;
    logic [DW-1:0]           r_acc;
    logic [NW-1:0]           r_rem;
    logic [SUM_W-1:0]        r_quo;
    logic                    r_neg;
    logic                    r_tok_vld;
    logic                    r_tok_have;
    logic [DW-1:0]           r_tok_dist;
    logic [CW-1:0]           r_tok_idx;

    logic                    w_mine;
    logic                    w_active;
    logic signed [VAL_W:0]   w_diff;
    logic signed [2*VAL_W+1:0] w_sq;
    logic signed [SUM_W-1:0] w_sel_sum;
    logic [SUM_W-1:0]        w_abs;
    logic [NW:0]             w_trial;
    logic                    w_ge;
    logic [SUM_W-1:0]        w_negq;
    logic signed [VAL_W-1:0] w_ctr_sel;

    assign w_mine    = (i_idx == CW'(IDX));
    assign w_active  = (CW'(IDX) < i_nc);
    assign w_ctr_sel = r_ctr[i_feat_sel];
    assign w_diff    = {i_value[VAL_W-1], i_value} - {w_ctr_sel[VAL_W-1], w_ctr_sel};
    assign w_sq      = w_diff * w_diff;
    assign w_sel_sum = r_sum[i_feat_sel];
    assign w_abs     = w_sel_sum[SUM_W-1] ? SUM_W'(-w_sel_sum) : SUM_W'(w_sel_sum);
    assign w_trial   = {r_rem, r_quo[SUM_W-1]};
    assign w_ge      = (w_trial >= {1'b0, r_cnt});
    assign w_negq    = -r_quo;
    assign o_rd_val  = w_ctr_sel;

    // Square the feature difference, then accumulate the distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_op.feat_vld;
        end
        r_prod <= w_sq[31:0];
        if (i_op.acc_clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + DW'(r_prod);
        end
    end

    // Pass the running minimum to the next cell, taking it over when closer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
        end
        if (w_active && (!i_tok_have || (r_acc < i_tok_dist))) begin
            r_tok_have <= 1'b1;
            r_tok_dist <= r_acc;
            r_tok_idx  <= CW'(IDX);
        end else begin
            r_tok_have <= i_tok_have;
            r_tok_dist <= i_tok_dist;
            r_tok_idx  <= i_tok_idx;
        end
    end

    assign o_tok_vld  = r_tok_vld;
    assign o_tok_have = r_tok_have;
    assign o_tok_dist = r_tok_dist;
    assign o_tok_idx  = r_tok_idx;

    // Accumulate per-cluster sums and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_op.pass_clr) begin
            r_cnt <= '0;
        end else if (i_op.upd && w_mine) begin
            r_cnt <= r_cnt + NW'(1);
        end
        for (int f = 0; f < MAX_FEATURES; f++) begin
            if (i_op.pass_clr) begin
                r_sum[f] <= '0;
            end else if (i_op.upd && w_mine && (f < int'(i_nf))) begin
                r_sum[f] <= r_sum[f] + {{(SUM_W-VAL_W){i_pt_buf[f][VAL_W-1]}}, i_pt_buf[f]};
            end
        end
    end

    // Divide one feature sum by the count, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_op.div_load) begin
            r_rem <= '0;
            r_quo <= w_abs;
            r_neg <= w_sel_sum[SUM_W-1];
        end else if (i_op.div_step) begin
            r_rem <= w_ge ? NW'(w_trial - {1'b0, r_cnt}) : NW'(w_trial);
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
    end

    // Load or replace center features
    always_ff @(posedge i_clk) begin
        if (i_op.ld_ctr && w_mine) begin
            r_ctr[i_feat_sel] <= i_value;
        end else if (i_op.div_wr && (r_cnt != '0) && (int'(i_feat_sel) < int'(i_nf))) begin
            r_ctr[i_feat_sel] <= r_neg ? w_negq[VAL_W-1:0] : r_quo[VAL_W-1:0];
        end
    end

    // Token timing through the cell
    a_tok_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_vld |=> o_tok_vld)
        else $error("min chain token lost in cell");

    // Count steps by one on a matching update
    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op.upd && w_mine && !i_op.pass_clr) |=> (r_cnt == $past(r_cnt) + NW'(1)))
        else $error("cluster count did not advance");

    // Remainder stays below a nonzero divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op.div_step && (r_cnt != '0) && !i_op.upd && !i_op.pass_clr) |=> (r_rem < r_cnt))
        else $error("divider remainder out of range");

endmodule

>>> sv/kmeans_lloyd_clustering.sv
// Top level of the k-means clustering engine: sequencer, stores and the cell chain.
//
// Load and read items pass through accept, store access and result register.
// A run item first sweeps the membership store to unassigned and then performs passes;
// each pass walks every point feature by feature through the point store, runs the
// minimum search along the chain of cluster cells, and ends with the bit-serial
// center division that all cells do in parallel. After reset the same sweep of the
// membership store runs before the first item is accepted; configuration writes are
// taken throughout.
module kmeans_lloyd_clustering #(
    parameter int MAX_POINTS   = kml_pkg::KML_MAX_POINTS,
    parameter int MAX_FEATURES = kml_pkg::KML_MAX_FEATURES,
    parameter int MAX_CLUSTERS = kml_pkg::KML_MAX_CLUSTERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [kml_pkg::CFG_W-1:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [9:0]  i_entry,
    input  logic [2:0]  i_feature_index,
    input  logic signed [15:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_read_value,
    output logic [4:0]  o_member,
    output logic [10:0] o_passes_done,
    output logic        o_bad_index
);
    import kml_pkg::*;

    localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int NFW = $clog2(MAX_FEATURES+1);
    localparam int CW  = $clog2(MAX_CLUSTERS+1);
    localparam int CIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW  = $clog2(MAX_POINTS+1);
    localparam int DW  = 32 + $clog2(MAX_FEATURES);
    localparam int DIV_LAST = SUM_W + 1;
    localparam logic [CW-1:0] UNASSIGNED = CW'(MAX_CLUSTERS);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_RESP   = 4'd3;
    localparam logic [3:0] S_RCLR   = 4'd4;
    localparam logic [3:0] S_PSTART = 4'd5;
    localparam logic [3:0] S_FEED   = 4'd6;
    localparam logic [3:0] S_DRAIN  = 4'd7;
    localparam logic [3:0] S_MIN    = 4'd8;
    localparam logic [3:0] S_UPD    = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_PEND   = 4'd11;

    // Configuration registers
    logic [3:0]  r_num_features;
    logic [4:0]  r_num_clusters;
    logic [10:0] r_num_points;
    logic [9:0]  r_loop_limit;
    logic [15:0] r_threshold_q16;
    logic        r_threshold_mode;

    logic [3:0]  r_state;
    logic [2:0]  r_kind;
    logic [9:0]  r_entry;
    logic [2:0]  r_feat;
    logic signed [VAL_W-1:0] r_val;
    logic        r_bad;
    logic [PW-1:0] r_clr;
    logic [PW-1:0] r_pt;
    logic [FW-1:0] r_f;
    logic        r_fv;
    logic [FW-1:0] r_fidx;
    logic        r_wait;
    logic        r_min_first;
    logic [CW-1:0] r_pick;
    logic [NW-1:0] r_changed;
    logic [FW-1:0] r_df;
    logic [5:0]  r_dstep;
    logic [10:0] r_pass_cnt;
    logic [10:0] r_loop;
    logic signed [VAL_W-1:0] r_pbuf [MAX_FEATURES];
    logic signed [VAL_W-1:0] r_pt_q;
    logic [CW-1:0] r_mem_q;

    logic        r_out_valid;
    logic signed [15:0] r_read_value;
    logic [4:0]  r_member;
    logic [10:0] r_passes_done;
    logic        r_bad_index;

    logic signed [VAL_W-1:0] m_pt  [MAX_POINTS << FW];
    logic [CW-1:0]           m_mem [MAX_POINTS];

    logic [NFW-1:0] w_nf;
    logic [CW-1:0]  w_nc;
    logic [NW-1:0]  w_np;
    logic           w_in_acc;
    logic           w_bad;
    logic           w_out_load;
    logic           w_more_thr;
    t_cell_op       w_op;
    logic [FW-1:0]  w_feat_sel;
    logic signed [VAL_W-1:0] w_value;
    logic [CW-1:0]  w_idx;
    logic           w_inj;

    logic           w_tok_vld  [MAX_CLUSTERS];
    logic           w_tok_have [MAX_CLUSTERS];
    logic [DW-1:0]  w_tok_dist [MAX_CLUSTERS];
    logic [CW-1:0]  w_tok_idx  [MAX_CLUSTERS];
    logic signed [VAL_W-1:0] w_rd [MAX_CLUSTERS];
    logic [CIW-1:0] w_last;

    // Clamp the sizes in use
    assign w_nf = (r_num_features == '0) ? NFW'(1) :
                  (int'(r_num_features) > MAX_FEATURES) ? NFW'(MAX_FEATURES) :
                  NFW'(r_num_features);
    assign w_nc = (r_num_clusters == '0) ? CW'(1) :
                  (int'(r_num_clusters) > MAX_CLUSTERS) ? CW'(MAX_CLUSTERS) :
                  CW'(r_num_clusters);
    assign w_np = (r_num_points == '0) ? NW'(1) :
                  (int'(r_num_points) > MAX_POINTS) ? NW'(MAX_POINTS) :
                  NW'(r_num_points);

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == S_RESP) && (!r_out_valid || !i_out_stall);
    assign w_last     = CIW'(w_nc - CW'(1));
    assign w_more_thr = ({r_changed, 16'd0} > (NW+16)'(r_threshold_q16 * w_np));

    // Flag an index outside the sizes in use
    always_comb begin
        case (r_kind)
            KIND_LOAD_CTR, KIND_READ_CTR:
                w_bad = (int'(r_entry) >= int'(w_nc)) || (int'(r_feat) >= int'(w_nf));
            KIND_LOAD_PT:
                w_bad = (int'(r_entry) >= int'(w_np)) || (int'(r_feat) >= int'(w_nf));
            KIND_READ_MEM:
                w_bad = (int'(r_entry) >= int'(w_np));
            default:
                w_bad = 1'b0;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_features   <= 4'd2;
            r_num_clusters   <= 5'd2;
            r_num_points     <= 11'd1024;
            r_loop_limit     <= 10'd500;
            r_threshold_q16  <= 16'd66;
            r_threshold_mode <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUM_FEATURES:   r_num_features   <= i_cfg_data[3:0];
                REG_NUM_CLUSTERS:   r_num_clusters   <= i_cfg_data[4:0];
                REG_NUM_POINTS:     r_num_points     <= i_cfg_data[10:0];
                REG_LOOP_LIMIT:     r_loop_limit     <= i_cfg_data[9:0];
                REG_THRESHOLD_Q16:  r_threshold_q16  <= i_cfg_data[15:0];
                REG_THRESHOLD_MODE: r_threshold_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Drive the cell strobes and broadcast buses
    always_comb begin
        w_op          = '0;
        w_op.acc_clr  = (r_state == S_FEED) && (r_f == '0);
        w_op.feat_vld = r_fv;
        w_op.pass_clr = (r_state == S_PSTART);
        w_op.upd      = (r_state == S_UPD);
        w_op.div_load = (r_state == S_DIV) && (r_dstep == 6'd0);
        w_op.div_step = (r_state == S_DIV) && (r_dstep != 6'd0) && (int'(r_dstep) < DIV_LAST);
        w_op.div_wr   = (r_state == S_DIV) && (int'(r_dstep) == DIV_LAST);
        w_op.ld_ctr   = (r_state == S_EXEC) && (r_kind == KIND_LOAD_CTR) && !w_bad;
        w_feat_sel    = r_fv ? r_fidx : ((r_state == S_DIV) ? r_df : FW'(r_feat));
        w_value       = r_fv ? r_pt_q : r_val;
        w_idx         = (r_state == S_UPD) ? r_pick : CW'(r_entry);
        w_inj         = (r_state == S_MIN) && r_min_first;
    end

    // Chain of cluster cells
    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
        logic          w_vi;
        logic          w_hi;
        logic [DW-1:0] w_di;
        logic [CW-1:0] w_ii;
        if (g == 0) begin : g_head
            assign w_vi = w_inj;
            assign w_hi = 1'b0;
            assign w_di = '0;
            assign w_ii = '0;
        end else begin : g_link
            assign w_vi = w_tok_vld[g-1];
            assign w_hi = w_tok_have[g-1];
            assign w_di = w_tok_dist[g-1];
            assign w_ii = w_tok_idx[g-1];
        end
        kml_cell #(
            .IDX          (g),
            .MAX_POINTS   (MAX_POINTS),
            .MAX_FEATURES (MAX_FEATURES),
            .MAX_CLUSTERS (MAX_CLUSTERS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (w_op),
            .i_feat_sel (w_feat_sel),
            .i_value    (w_value),
            .i_idx      (w_idx),
            .i_pt_buf   (r_pbuf),
            .i_nf       (w_nf),
            .i_nc       (w_nc),
            .i_tok_vld  (w_vi),
            .i_tok_have (w_hi),
            .i_tok_dist (w_di),
            .i_tok_idx  (w_ii),
            .o_tok_vld  (w_tok_vld[g]),
            .o_tok_have (w_tok_have[g]),
            .o_tok_dist (w_tok_dist[g]),
            .o_tok_idx  (w_tok_idx[g]),
            .o_rd_val   (w_rd[g])
        );
    end

    // Point store: write on load, read one feature a cycle during a pass
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EXEC) && (r_kind == KIND_LOAD_PT) && !w_bad) begin
            m_pt[{PW'(r_entry), FW'(r_feat)}] <= r_val;
        end
        if (r_state == S_FEED) begin
            r_pt_q <= m_pt[{r_pt, r_f}];
        end
    end

    // Membership store: clear sweep, update, and read for items and passes
    always_ff @(posedge i_clk) begin
        if ((r_state == S_CLEAR) || (r_state == S_RCLR)) begin
            m_mem[r_clr] <= UNASSIGNED;
        end else if (r_state == S_UPD) begin
            m_mem[r_pt] <= r_pick;
        end
        if (r_state == S_EXEC) begin
            r_mem_q <= m_mem[PW'(r_entry)];
        end else if (r_state == S_FEED) begin
            r_mem_q <= m_mem[r_pt];
        end
    end

    // Buffer the point features for the sum update
    always_ff @(posedge i_clk) begin
        r_fidx <= r_f;
        if (r_fv) begin
            r_pbuf[r_fidx] <= r_pt_q;
        end
    end

    // Sequence items, passes and points
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_fv        <= 1'b0;
            r_pass_cnt  <= '0;
            r_min_first <= 1'b0;
        end else begin
            r_fv <= (r_state == S_FEED);
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + PW'(1);
                    if (int'(r_clr) == MAX_POINTS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_kind  <= i_kind;
                        r_entry <= i_entry;
                        r_feat  <= i_feature_index;
                        r_val   <= i_value;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_bad <= w_bad;
                    if (r_kind == KIND_RUN) begin
                        r_clr   <= '0;
                        r_state <= S_RCLR;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RCLR: begin
                    r_clr <= r_clr + PW'(1);
                    if (int'(r_clr) == MAX_POINTS - 1) begin
                        r_pass_cnt <= '0;
                        r_loop     <= '0;
                        r_state    <= S_PSTART;
                    end
                end
                S_PSTART: begin
                    r_changed <= '0;
                    r_pt      <= '0;
                    r_f       <= '0;
                    r_state   <= S_FEED;
                end
                S_FEED: begin
                    if (int'(r_f) == int'(w_nf) - 1) begin
                        r_wait  <= 1'b0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_f <= r_f + FW'(1);
                    end
                end
                S_DRAIN: begin
                    r_wait <= 1'b1;
                    if (r_wait) begin
                        r_min_first <= 1'b1;
                        r_state     <= S_MIN;
                    end
                end
                S_MIN: begin
                    r_min_first <= 1'b0;
                    if (w_tok_vld[w_last]) begin
                        r_pick  <= w_tok_idx[w_last];
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_mem_q != r_pick) begin
                        r_changed <= r_changed + NW'(1);
                    end
                    r_f <= '0;
                    if (int'(r_pt) == int'(w_np) - 1) begin
                        r_df    <= '0;
                        r_dstep <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_pt    <= r_pt + PW'(1);
                        r_state <= S_FEED;
                    end
                end
                S_DIV: begin
                    if (int'(r_dstep) == DIV_LAST) begin
                        r_dstep <= '0;
                        if (int'(r_df) == int'(w_nf) - 1) begin
                            r_state <= S_PEND;
                        end else begin
                            r_df <= r_df + FW'(1);
                        end
                    end else begin
                        r_dstep <= r_dstep + 6'd1;
                    end
                end
                S_PEND: begin
                    r_pass_cnt <= r_pass_cnt + 11'd1;
                    if (r_threshold_mode && !w_more_thr) begin
                        r_bad   <= 1'b0;
                        r_state <= S_RESP;
                    end else begin
                        r_loop <= r_loop + 11'd1;
                        if (r_loop < 11'(r_loop_limit)) begin
                            r_state <= S_PSTART;
                        end else begin
                            r_bad   <= 1'b0;
                            r_state <= S_RESP;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_read_value  <= ((r_kind == KIND_READ_CTR) && !r_bad) ?
                             w_rd[CIW'(r_entry)] : 16'sd0;
            r_member      <= ((r_kind == KIND_READ_MEM) && !r_bad) ? 5'(r_mem_q) : 5'd0;
            r_passes_done <= r_pass_cnt;
            r_bad_index   <= r_bad && (r_kind != KIND_RUN);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_member      = r_member;
    assign o_passes_done = r_passes_done;
    assign o_bad_index   = r_bad_index;

    // The picked cluster is one in use
    a_pick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_pick < w_nc))
        else $error("picked cluster out of range");

    // Changed memberships never outrun the points walked
    a_changed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (int'(r_changed) <= int'(r_pt)))
        else $error("changed count exceeds points visited");

    // A membership read during a pass holds a legal code
    a_mem_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_mem_q <= UNASSIGNED))
        else $error("membership store holds an illegal code");

endmodule

>>> tb/kmeans_lloyd_clustering_tb.sv
// Self-checking testbench of the k-means clustering engine, with its own Lloyd predictor.
`timescale 1ns / 1ps
module kmeans_lloyd_clustering_tb;
    import kml_pkg::*;

    localparam int QUIET_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] read_value;
        logic [4:0]         member;
        logic [10:0]        passes;
        logic               bad;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [2:0] i_kind = '0;
    logic [9:0] i_entry = '0;
    logic [2:0] i_feature_index = '0;
    logic signed [15:0] i_value = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [15:0] o_read_value;
    logic [4:0] o_member;
    logic [10:0] o_passes_done;
    logic o_bad_index;

    // Mirror of the engine state
    int unsigned cfg_reg [6];
    logic signed [15:0] ctr_mirror [KML_MAX_CLUSTERS][KML_MAX_FEATURES];
    logic signed [15:0] pt_mirror [KML_MAX_POINTS][KML_MAX_FEATURES];
    bit ctr_loaded [KML_MAX_CLUSTERS][KML_MAX_FEATURES];
    bit pt_loaded [KML_MAX_POINTS][KML_MAX_FEATURES];
    logic [4:0] member_mirror [KML_MAX_POINTS];
    logic [10:0] passes_mirror;

    t_answer answer_q [$];
    int fail_cnt = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    int next_gap = 0;
    int out_hold = 0;
    bit in_hold = 1'b0;
    bit idle_en = 1'b1;

    kmeans_lloyd_clustering u_top (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_size(int idx, int hi);
        if (cfg_reg[idx] == 0) return 1;
        return (cfg_reg[idx] > hi) ? hi : cfg_reg[idx];
    endfunction

    function automatic bit all_loaded();
        int nf, nc, np;
        nf = eff_size(REG_NUM_FEATURES, KML_MAX_FEATURES);
        nc = eff_size(REG_NUM_CLUSTERS, KML_MAX_CLUSTERS);
        np = eff_size(REG_NUM_POINTS, KML_MAX_POINTS);
        for (int f = 0; f < nf; f++) begin
            for (int c = 0; c < nc; c++) if (!ctr_loaded[c][f]) return 1'b0;
            for (int p = 0; p < np; p++) if (!pt_loaded[p][f]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Full Lloyd iteration on the mirror: clear memberships, then passes
    task automatic lloyd_run();
        int nf, nc, np, loop_cnt, changed, pick;
        longint best, sq_sum, diff;
        longint sums [KML_MAX_CLUSTERS][KML_MAX_FEATURES];
        int counts [KML_MAX_CLUSTERS];
        bit more;
        nf = eff_size(REG_NUM_FEATURES, KML_MAX_FEATURES);
        nc = eff_size(REG_NUM_CLUSTERS, KML_MAX_CLUSTERS);
        np = eff_size(REG_NUM_POINTS, KML_MAX_POINTS);
        loop_cnt = 0;
        for (int p = 0; p < KML_MAX_POINTS; p++) member_mirror[p] = 5'd16;
        passes_mirror = '0;
        do begin
            changed = 0;
            for (int c = 0; c < KML_MAX_CLUSTERS; c++) begin
                counts[c] = 0;
                for (int f = 0; f < KML_MAX_FEATURES; f++) sums[c][f] = 0;
            end
            // assign each point; lower index wins a tie
            for (int p = 0; p < np; p++) begin
                best = 0;
                pick = 0;
                for (int c = 0; c < nc; c++) begin
                    sq_sum = 0;
                    for (int f = 0; f < nf; f++) begin
                        diff = longint'(pt_mirror[p][f]) - longint'(ctr_mirror[c][f]);
                        sq_sum += diff * diff;
                    end
                    if (c == 0 || sq_sum < best) begin
                        best = sq_sum;
                        pick = c;
                    end
                end
                if (member_mirror[p] != 5'(pick)) changed++;
                member_mirror[p] = 5'(pick);
                counts[pick]++;
                for (int f = 0; f < nf; f++) sums[pick][f] += longint'(pt_mirror[p][f]);
            end
            // move non-empty centers to the truncated mean; keep empty ones
            for (int c = 0; c < nc; c++) begin
                if (counts[c] > 0) begin
                    for (int f = 0; f < nf; f++)
                        ctr_mirror[c][f] = 16'(sums[c][f] / longint'(counts[c]));
                end
            end
            passes_mirror++;
            if (cfg_reg[REG_THRESHOLD_MODE] != 0) begin
                more = longint'(changed) * 65536 >
                       longint'(cfg_reg[REG_THRESHOLD_Q16]) * longint'(np);
                if (more) more = (loop_cnt++ < int'(cfg_reg[REG_LOOP_LIMIT]));
            end else begin
                more = (loop_cnt++ < int'(cfg_reg[REG_LOOP_LIMIT]));
            end
        end while (more);
    endtask

    // Work out the answer to one accepted transaction
    task automatic predict_item(logic [2:0] kind, logic [9:0] entry, logic [2:0] feat,
                                logic signed [15:0] value);
        t_answer ans;
        int nf, nc, np;
        nf = eff_size(REG_NUM_FEATURES, KML_MAX_FEATURES);
        nc = eff_size(REG_NUM_CLUSTERS, KML_MAX_CLUSTERS);
        np = eff_size(REG_NUM_POINTS, KML_MAX_POINTS);
        ans = '{read_value: '0, member: '0, passes: '0, bad: 1'b0};
        case (kind)
            KIND_LOAD_CTR: begin
                if (entry >= nc || feat >= nf) ans.bad = 1'b1;
                else begin
                    ctr_mirror[entry][feat] = value;
                    ctr_loaded[entry][feat] = 1'b1;
                end
            end
            KIND_LOAD_PT: begin
                if (entry >= np || feat >= nf) ans.bad = 1'b1;
                else begin
                    pt_mirror[entry][feat] = value;
                    pt_loaded[entry][feat] = 1'b1;
                end
            end
            KIND_RUN: lloyd_run();
            KIND_READ_MEM: begin
                if (entry >= np) ans.bad = 1'b1;
                else ans.member = member_mirror[entry];
            end
            KIND_READ_CTR: begin
                if (entry >= nc || feat >= nf) ans.bad = 1'b1;
                else ans.read_value = ctr_mirror[entry][feat];
            end
            default: ;
        endcase
        ans.passes = passes_mirror;
        answer_q.push_back(ans);
    endtask

    // Send one transaction; valid stays up only when the next one follows at once
    task automatic send_item(logic [2:0] kind, int entry, int feat, logic signed [15:0] value);
        if (!in_hold) repeat (next_gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_entry <= 10'(entry);
        i_feature_index <= 3'(feat);
        i_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(kind, 10'(entry), 3'(feat), value);
        items_sent++;
        next_gap = idle_en ? $urandom_range(0, 18) : 0;
        in_hold = (next_gap == 0);
        if (!in_hold) i_in_valid <= 1'b0;
    endtask

    // Drop valid and wait until every answer has come back
    task automatic drain();
        if (in_hold) begin
            i_in_valid <= 1'b0;
            in_hold = 1'b0;
        end
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write all six registers back to back while the engine is idle
    task automatic set_config(int nf, int nc, int np, int max_it, int thr, int mode);
        int vals [6];
        int widths [6];
        vals = '{nf, nc, np, max_it, thr, mode};
        widths = '{4, 5, 11, 10, 16, 1};
        drain();
        for (int r = 0; r < 6; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(r);
            i_cfg_data <= CFG_W'(vals[r]);
            @(posedge i_clk);
            cfg_reg[r] = vals[r] & ((1 << widths[r]) - 1);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_value(int group);
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom);
            default: return 16'(group * 1500 - 6000 + $urandom_range(0, 400));
        endcase
    endfunction

    // Fill every center and point in use with fresh values
    task automatic load_all();
        int nf, nc, np;
        nf = eff_size(REG_NUM_FEATURES, KML_MAX_FEATURES);
        nc = eff_size(REG_NUM_CLUSTERS, KML_MAX_CLUSTERS);
        np = eff_size(REG_NUM_POINTS, KML_MAX_POINTS);
        for (int c = 0; c < nc; c++)
            for (int f = 0; f < nf; f++) send_item(KIND_LOAD_CTR, c, f, rand_value(c % 8));
        for (int p = 0; p < np; p++)
            for (int f = 0; f < nf; f++)
                send_item(KIND_LOAD_PT, p, f, rand_value($urandom_range(0, 7)));
    endtask

    task automatic test_reset_state();
        send_item(KIND_READ_MEM, 0, 0, '0);
        send_item(KIND_READ_MEM, 1023, 7, 16'sh7fff);
        send_item(KIND_READ_CTR, 2, 0, '0);
        send_item(KIND_LOAD_CTR, 1023, 7, 16'sh8000);
        send_item(3'd5, 1023, 7, -16'sd1);
        send_item(3'd6, 0, 0, '0);
        send_item(3'd7, 512, 3, 16'sh5555);
    endtask

    task automatic test_size_extremes();
        // oversized values clamp to the maximum sizes
        set_config(15, 31, 2047, 0, 65535, 1);
        send_item(KIND_LOAD_CTR, 15, 7, 16'sh7fff);
        send_item(KIND_READ_CTR, 15, 7, '0);
        send_item(KIND_LOAD_PT, 1023, 7, 16'sh8000);
        send_item(KIND_READ_MEM, 1023, 0, '0);
        send_item(KIND_LOAD_CTR, 16, 0, '0);
        // zero sizes act as one
        set_config(0, 0, 0, 0, 0, 0);
        send_item(KIND_LOAD_PT, 1, 0, '0);
        send_item(KIND_LOAD_CTR, 0, 1, '0);
        send_item(KIND_LOAD_CTR, 0, 0, 16'sh8000);
        send_item(KIND_LOAD_PT, 0, 0, 16'sh7fff);
        send_item(KIND_RUN, 0, 0, '0);
        send_item(KIND_READ_MEM, 0, 0, '0);
        send_item(KIND_READ_CTR, 0, 0, '0);
    endtask

    task automatic test_full_pass_limit();
        // no early stop: loop limit + 1 passes
        set_config(1, 1, 2, 1023, 0, 0);
        send_item(KIND_LOAD_CTR, 0, 0, 16'sd100);
        send_item(KIND_LOAD_PT, 0, 0, -16'sd300);
        send_item(KIND_LOAD_PT, 1, 0, 16'sd301);
        send_item(KIND_RUN, 0, 0, '0);
    endtask

    task automatic test_tie_break();
        // point equidistant from both centers goes to the lower index
        set_config(1, 2, 1, 5, 66, 1);
        send_item(KIND_LOAD_CTR, 0, 0, -16'sd256);
        send_item(KIND_LOAD_CTR, 1, 0, 16'sd256);
        send_item(KIND_LOAD_PT, 0, 0, '0);
        send_item(KIND_RUN, 0, 0, '0);
        send_item(KIND_READ_MEM, 0, 0, '0);
    endtask

    task automatic test_random_phases();
        int nf, nc, np, kind, entry, feat;
        while (items_sent < 670) begin
            idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                set_config(8, 16, $urandom_range(1, 4), $urandom_range(0, 12),
                           $urandom, $urandom_range(0, 1));
            else
                set_config($urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 16),
                           $urandom_range(0, 12), ($urandom_range(0, 2) == 0) ? 0 : $urandom,
                           $urandom_range(0, 1));
            nf = eff_size(REG_NUM_FEATURES, KML_MAX_FEATURES);
            nc = eff_size(REG_NUM_CLUSTERS, KML_MAX_CLUSTERS);
            np = eff_size(REG_NUM_POINTS, KML_MAX_POINTS);
            load_all();
            send_item(KIND_RUN, 0, 0, 16'($urandom));
            repeat (30) begin
                kind = $urandom_range(0, 19);
                entry = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, np);
                feat = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                    : $urandom_range(0, nf - 1);
                if (kind < 4) begin
                    send_item(KIND_LOAD_PT, entry, feat, rand_value($urandom_range(0, 7)));
                end else if (kind < 6) begin
                    send_item(KIND_LOAD_CTR, entry % (nc + 1), feat, rand_value(0));
                end else if (kind < 11) begin
                    send_item(KIND_READ_MEM, entry, $urandom_range(0, 7), 16'($urandom));
                end else if (kind < 16) begin
                    entry = entry % (nc + 1);
                    if (entry < nc && feat < nf && !ctr_loaded[entry][feat]) entry = nc;
                    send_item(KIND_READ_CTR, entry, feat, 16'($urandom));
                end else if (kind < 18) begin
                    if (all_loaded()) send_item(KIND_RUN, entry, feat, '0);
                end else begin
                    send_item(3'($urandom_range(5, 7)), $urandom_range(0, 1023),
                              $urandom_range(0, 7), 16'($urandom));
                end
            end
        end
    endtask

    // Stall the result side for a random number of cycles after each transaction
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            out_hold = idle_en ? $urandom_range(0, 18) : 0;
            i_out_stall <= (out_hold != 0);
        end else if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= (out_hold != 0);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result rv=%0d member=%0d passes=%0d bad=%0b",
                         $time, o_read_value, o_member, o_passes_done, o_bad_index);
                fail_cnt++;
            end else begin
                exp_ans = answer_q.pop_front();
                if (o_read_value !== exp_ans.read_value || o_member !== exp_ans.member ||
                    o_passes_done !== exp_ans.passes || o_bad_index !== exp_ans.bad) begin
                    $display("%0t: expected rv=%0d member=%0d passes=%0d bad=%0b", $time,
                             exp_ans.read_value, exp_ans.member, exp_ans.passes, exp_ans.bad);
                    $display("%0t: actual   rv=%0d member=%0d passes=%0d bad=%0b", $time,
                             o_read_value, o_member, o_passes_done, o_bad_index);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("kmeans_lloyd_clustering regression: fail");
            $finish;
        end
    end

    initial begin
        cfg_reg = '{2, 2, 1024, 500, 66, 1};
        for (int p = 0; p < KML_MAX_POINTS; p++) member_mirror[p] = 5'd16;
        passes_mirror = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_size_extremes();
        test_full_pass_limit();
        test_tie_break();
        test_random_phases();
        drain();
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0) $display("kmeans_lloyd_clustering regression: pass");
        else $display("kmeans_lloyd_clustering regression: fail");
        $finish;
    end

endmodule
